### sv/tlt_pkg.sv
// Package for the timed lock table: payload types, codes and cell control types.
`timescale 1ns / 1ps

package tlt_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;
   localparam logic [30:0] TIMEOUT_RESET = 31'd300000;

   localparam logic [1:0] OP_TAKE    = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_QUERY   = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NOMATCH = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] item_id;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic       is_locked;
      logic [1:0] status;
      logic [4:0] entries_used;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP
   } state_type;

   typedef enum logic [2:0] {
      CMD_HOLD,
      CMD_LOAD,
      CMD_DROP_ID,
      CMD_MARK,
      CMD_DROP_DEAD
   } cell_cmd_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      cell_cmd_type cmd;
      logic [31:0]  key;
      logic [31:0]  stamp;
      logic [31:0]  base;
   } cell_ctrl_type;

   // Contents that move from a cell to its left neighbor.
   typedef struct packed {
      logic [31:0] id;
      logic [31:0] stamp;
      logic        dead;
   } cell_data_type;

endpackage

### sv/tlt_cell.sv
// One cell of the lock row: holds one entry and shifts from its right neighbor.
`timescale 1ns / 1ps

module tlt_cell #(
   parameter int INDEX = 0,
   parameter int TABLE_ENTRIES = tlt_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  tlt_pkg::cell_ctrl_type              ctrl,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0]  count,
   input  logic                                hit_in,
   input  tlt_pkg::cell_data_type              right_in,
   output tlt_pkg::cell_data_type              data_out,
   output logic                                hit_out,
   output logic                                match
);
   import tlt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   cell_data_type data_ff;
   cell_data_type data_in;
   logic          valid;
   logic          kill;
   logic          expired;
   logic [31:0]   diff;

   // The live entries always form a prefix of the row.
   assign valid = IDX < count;
   assign diff = ctrl.base - data_ff.stamp;
   assign expired = (diff != 32'd0) && !diff[31];
   assign match = valid && (data_ff.id == ctrl.key);

   always_comb begin
      case (ctrl.cmd)
         CMD_DROP_ID:   kill = match;
         CMD_DROP_DEAD: kill = valid && data_ff.dead;
         default:       kill = 1'b0;
      endcase
   end

   // Once a removal has happened here or further left, this cell takes its right neighbor.
   assign hit_out = hit_in | kill;

   always_comb begin
      data_in = data_ff;
      case (ctrl.cmd)
         CMD_LOAD: begin
            if (count == IDX) begin
               data_in.id    = ctrl.key;
               data_in.stamp = ctrl.stamp;
               data_in.dead  = 1'b0;
            end
         end
         CMD_DROP_ID, CMD_DROP_DEAD: begin
            if (hit_out) begin
               data_in = right_in;
            end
         end
         CMD_MARK: begin
            data_in.dead = valid && expired;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

### sv/tlt_row.sv
// Row of lock cells chained left to right, with match and removal summaries.
`timescale 1ns / 1ps

module tlt_row #(
   parameter int TABLE_ENTRIES = tlt_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  tlt_pkg::cell_ctrl_type              ctrl,
   input  logic [$clog2(TABLE_ENTRIES+1)-1:0]  count,
   output logic                                hit_any,
   output logic                                match_any
);
   import tlt_pkg::*;

   cell_data_type              data [TABLE_ENTRIES];
   logic [TABLE_ENTRIES:0]     hit_chain;
   logic [TABLE_ENTRIES-1:0]   match_vec;

   assign hit_chain[0] = 1'b0;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      cell_data_type right;

      if (i == TABLE_ENTRIES - 1) begin : g_last
         assign right = '0;
      end else begin : g_inner
         assign right = data[i+1];
      end

      tlt_cell #(
         .INDEX         (i),
         .TABLE_ENTRIES (TABLE_ENTRIES)
      ) u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .count    (count),
         .hit_in   (hit_chain[i]),
         .right_in (right),
         .data_out (data[i]),
         .hit_out  (hit_chain[i+1]),
         .match    (match_vec[i])
      );
   end

   assign hit_any   = hit_chain[TABLE_ENTRIES];
   assign match_any = |match_vec;

endmodule

### sv/timed_lock_table.sv
// Top level of the timed lock table: sequencer, count, timeout register and response.
//
//   channel  ports                           direction  accepted when
//   request  start, busy, req_data           in         start && !busy
//   result   rsp_strobe, rsp_data            out        every cycle rsp_strobe is high
//   config   csr_wr_en, csr_wr_data          in         csr_wr_en
//
// Take, release and the unused op run through the accept cycle and ST_EXEC, in which the
// cell row appends or removes in a single shift.
// A query runs a marking pass in ST_EXEC, then removes the expired entries one at a time
// through the shared removal chain in ST_SWEEP, then does the lookup.
// The result is strobed in the cycle after the last working cycle, when busy is already
// low, so the next item may be accepted in the same cycle. Results cannot be stalled.
// Reset empties the table at once; there is no clearing pass.
`timescale 1ns / 1ps

module timed_lock_table #(
   parameter int TABLE_ENTRIES = tlt_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tlt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tlt_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [30:0]      csr_wr_data
);
   import tlt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   state_type      state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [30:0]    timeout_ff;
   req_type        req_ff, req_in;
   logic [31:0]    base_ff, base_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   rsp_type        rsp_ff, rsp_in;
   cell_ctrl_type  ctrl;
   logic           hit_any;
   logic           match_any;
   logic           accept;

   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;

   // Capture the item; the expiry base folds now and the timeout into one value.
   assign req_in  = accept ? req_data : req_ff;
   assign base_in = accept ? (req_data.now - {1'b0, timeout_ff}) : base_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = (req_ff.op == OP_QUERY) ? ST_SWEEP : ST_IDLE;
         end
         ST_SWEEP: begin
            state_in = hit_any ? ST_SWEEP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctrl.cmd      = CMD_HOLD;
      ctrl.key      = req_ff.item_id;
      ctrl.stamp    = req_ff.now;
      ctrl.base     = base_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_in.is_locked = 1'b0;
      rsp_in.status    = STATUS_OK;
      case (state_ff)
         ST_EXEC: begin
            case (req_ff.op)
               OP_TAKE: begin
                  rsp_strobe_in = 1'b1;
                  if (count_ff == FULL_COUNT) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     ctrl.cmd = CMD_LOAD;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_RELEASE: begin
                  ctrl.cmd      = CMD_DROP_ID;
                  rsp_strobe_in = 1'b1;
                  if (hit_any) begin
                     count_in = count_ff - 1'b1;
                  end else begin
                     rsp_in.status = STATUS_NOMATCH;
                  end
               end
               OP_QUERY: begin
                  ctrl.cmd = CMD_MARK;
               end
               default: begin
                  rsp_strobe_in = 1'b1;
               end
            endcase
         end
         ST_SWEEP: begin
            // Removes the leftmost expired entry each cycle; the lookup runs once none is left.
            ctrl.cmd = CMD_DROP_DEAD;
            if (hit_any) begin
               count_in = count_ff - 1'b1;
            end else begin
               rsp_strobe_in    = 1'b1;
               rsp_in.is_locked = match_any;
            end
         end
         default: begin
            ctrl.cmd = CMD_HOLD;
         end
      endcase
      rsp_in.entries_used = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         timeout_ff    <= TIMEOUT_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      base_ff <= base_in;
      rsp_ff  <= rsp_in;
   end

   tlt_row #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_row (
      .clock     (clock),
      .ctrl      (ctrl),
      .count     (count_ff),
      .hit_any   (hit_any),
      .match_any (match_any)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds the table size");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_in |-> (state_ff == ST_EXEC || state_ff == ST_SWEEP))
      else $error("result strobed outside a working state");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not make the block busy");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_in && rsp_in.status == STATUS_FULL) |=> count_ff == FULL_COUNT)
      else $error("dropped take changed the table");

   a_sweep_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && hit_any) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("expiry removal did not shrink the table by one");
`endif

endmodule
